>>> src/pse_pkg.sv
// Package for the PLL setting encoder: field widths, status codes, limits,
// LFSR seeds and the request structs shared by the sequencer and its units.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package pse_pkg;

  // Payload widths
  localparam int unsigned MULT_W   = 16;
  localparam int unsigned DIV_W    = 7;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned SRC_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MDEC_W   = 17;
  localparam int unsigned NDEC_W   = 10;
  localparam int unsigned PDEC_W   = 7;
  localparam int unsigned SELI_W   = 7;
  localparam int unsigned SELP_W   = 5;

  // Internal widths
  localparam int unsigned MSEL_W   = 15;  // msel never exceeds 32767
  localparam int unsigned PSEL_W   = 6;   // psel up to 32
  localparam int unsigned CCO_W    = 48;  // 32 x 16 product
  localparam int unsigned LFSR_W   = 15;
  localparam int unsigned DVS_W    = 10;  // divider divisor width

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd2;

  // Limits
  localparam logic [CCO_W-1:0]  CCO_MIN  = 48'd275000000;
  localparam logic [CCO_W-1:0]  CCO_MAX  = 48'd550000000;
  localparam logic [MULT_W-1:0] MULT_MAX = 16'd32768;
  localparam logic [DIV_W-1:0]  DIV_MAX  = 7'd64;

  // Encoded constants
  localparam logic [MDEC_W-1:0] MDEC_ONE   = 17'h18003;
  localparam logic [MDEC_W-1:0] MDEC_TWO   = 17'h10003;
  localparam logic [NDEC_W-1:0] NDEC_ONE   = 10'h302;
  localparam logic [NDEC_W-1:0] NDEC_TWO   = 10'h202;
  localparam logic [PDEC_W-1:0] PDEC_DIRECT = 7'h7F;
  localparam logic [PDEC_W-1:0] PDEC_ONE   = 7'h62;
  localparam logic [PDEC_W-1:0] PDEC_TWO   = 7'h42;

  // LFSR seeds and step counts
  localparam logic [LFSR_W-1:0] SEED_M   = 15'h4000;
  localparam logic [LFSR_W-1:0] SEED_P   = 15'h0010;
  localparam logic [MULT_W-1:0] M_STEPS_BASE = 16'd32769;  // steps = base - msel
  localparam logic [PSEL_W-1:0] P_STEPS_BASE = 6'd33;      // steps = base - psel

  // Bandwidth thresholds
  localparam logic [MSEL_W-1:0] BW_T1 = 15'd16384;
  localparam logic [MSEL_W-1:0] BW_T2 = 15'd8192;
  localparam logic [MSEL_W-1:0] BW_T3 = 15'd2048;
  localparam logic [MSEL_W-1:0] BW_T4 = 15'd501;
  localparam logic [MSEL_W-1:0] BW_T5 = 15'd60;
  localparam logic [FREQ_W-1:0] BW_NUM = 32'd1024;
  localparam logic [DVS_W-1:0]  BW_OFS = 10'd9;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic              mode_p;   // 1: 5-bit post-divider LFSR, 0: 15-bit multiplier LFSR
    logic [LFSR_W-1:0] steps;
  } lfsr_req_t;

  typedef struct packed {
    logic              done;
    logic [LFSR_W-1:0] value;
  } lfsr_rsp_t;

endpackage

`default_nettype wire

>>> src/pse_in_if.sv
// Request channel of the PLL setting encoder: valid/ready plus the request fields.
// Depends on pse_pkg for the field widths.
`default_nettype none

interface pse_in_if;
  logic                           valid;
  logic                           ready;
  logic [pse_pkg::MULT_W-1:0]     multiplier;
  logic [pse_pkg::DIV_W-1:0]      divisor;
  logic [pse_pkg::FREQ_W-1:0]     source_frequency;
  logic [pse_pkg::SRC_W-1:0]      source_select;
  logic                           is_audio;

  modport source (output valid, multiplier, divisor, source_frequency, source_select,
                  is_audio, input ready);
  modport sink   (input valid, multiplier, divisor, source_frequency, source_select,
                  is_audio, output ready);
endinterface

`default_nettype wire

>>> src/pse_out_if.sv
// Result channel of the PLL setting encoder: valid/ready plus the encoded fields.
// Depends on pse_pkg for the field widths.
`default_nettype none

interface pse_out_if;
  logic                           valid;
  logic                           ready;
  logic [pse_pkg::STATUS_W-1:0]   status;
  logic [pse_pkg::MDEC_W-1:0]     mdec;
  logic [pse_pkg::NDEC_W-1:0]     ndec;
  logic [pse_pkg::PDEC_W-1:0]     pdec;
  logic [pse_pkg::SELI_W-1:0]     seli;
  logic [pse_pkg::SELP_W-1:0]     selp;
  logic                           direct_input;
  logic                           direct_output;
  logic                           audio_extras;
  logic [pse_pkg::SRC_W-1:0]      clock_source;
  logic [pse_pkg::FREQ_W-1:0]     expected_frequency;

  modport source (output valid, status, mdec, ndec, pdec, seli, selp, direct_input,
                  direct_output, audio_extras, clock_source, expected_frequency,
                  input ready);
  modport sink   (input valid, status, mdec, ndec, pdec, seli, selp, direct_input,
                  direct_output, audio_extras, clock_source, expected_frequency,
                  output ready);
endinterface

`default_nettype wire

>>> src/pse_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on pse_pkg for widths and the request/response structs.
`default_nettype none

module pse_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pse_pkg::div_req_t req,
  output pse_pkg::div_rsp_t      rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [4:0]                    cnt_r;
  logic [pse_pkg::FREQ_W-1:0]    quo_r;
  logic [pse_pkg::DVS_W-1:0]     rem_r;
  logic [pse_pkg::DVS_W-1:0]     dvs_r;

  logic [pse_pkg::DVS_W:0]       trial;
  logic [pse_pkg::DVS_W:0]       diff;
  logic                          fits;

  assign trial = {rem_r, quo_r[pse_pkg::FREQ_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient in through the same register
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[pse_pkg::FREQ_W-2:0], fits};
      rem_r <= fits ? diff[pse_pkg::DVS_W-1:0] : trial[pse_pkg::DVS_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

>>> src/pse_lfsr_unit.sv
// Shared LFSR stepper: runs the 15-bit multiplier or 5-bit post-divider LFSR
// from its seed for a given number of steps, one step per cycle. Uses pse_pkg.
`default_nettype none

module pse_lfsr_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pse_pkg::lfsr_req_t req,
  output pse_pkg::lfsr_rsp_t      rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic                          mode_p_r;
  logic [pse_pkg::LFSR_W-1:0]    cnt_r;
  logic [pse_pkg::LFSR_W-1:0]    x_r;
  logic [pse_pkg::LFSR_W-1:0]    x_nxt;

  // Multiplier taps bits 0 and 1 into bit 14; post-divider taps bits 0 and 2 into bit 4
  always_comb begin
    if (mode_p_r) begin
      x_nxt = {10'd0, x_r[0] ^ x_r[2], x_r[4:1]};
    end else begin
      x_nxt = {x_r[0] ^ x_r[1], x_r[pse_pkg::LFSR_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pse_pkg::LFSR_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_p_r <= req.mode_p;
      x_r      <= req.mode_p ? pse_pkg::SEED_P : pse_pkg::SEED_M;
    end else if (busy_r) begin
      x_r <= x_nxt;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = x_r;

endmodule

`default_nettype wire

>>> src/pll_setting_encoder_unit.sv
// PLL setting encoder top level: request checking, sequencer and result register.
// Depends on pse_pkg, pse_in_if, pse_out_if, pse_divider and pse_lfsr_unit.
//
// Each request (multiplier M, divisor P, reference frequency, source, channel)
// is checked, turned into msel/nsel/psel, and encoded into the mdec, ndec and
// pdec codes, the seli/selp bandwidth fields, the bypass flags and the expected
// output frequency. One request is handled at a time: in_ch.ready is high only
// while the sequencer is idle, and the finished result waits in an output
// register, so the next request can transfer while the previous result is
// still unclaimed. The mdec code comes from the 15-bit multiplier LFSR, which
// advances one step per cycle for 32769 - msel steps (msel of 3 or more).
// The shared serial divider forms the expected frequency when P is not 1,
// and the seli field when msel lies in 60..500; the post-divider LFSR runs
// 33 - psel steps for pdec when psel is 3 or more. The oscillator frequency
// is formed by one 32 x 16 multiply at full width, so no wrap can pass a bad
// product through the 275..550 MHz range check. On any failed check, every
// field but status reads zero and the per-channel frequency record holds; on
// success the expected frequency is recorded for the audio or USB channel as
// the result is loaded.
`default_nettype none

module pll_setting_encoder_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pse_in_if.sink     in_ch,
  pse_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_RANGE  = 4'd3;
  localparam logic [3:0] S_DIVF   = 4'd4;
  localparam logic [3:0] S_BAND   = 4'd5;
  localparam logic [3:0] S_DIVB   = 4'd6;
  localparam logic [3:0] S_LFM_GO = 4'd7;
  localparam logic [3:0] S_LFM_WT = 4'd8;
  localparam logic [3:0] S_LFP_GO = 4'd9;
  localparam logic [3:0] S_LFP_WT = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Latched request
  logic [pse_pkg::MULT_W-1:0]   mult_r;
  logic [pse_pkg::DIV_W-1:0]    div_r;
  logic [pse_pkg::FREQ_W-1:0]   fin_r;
  logic [pse_pkg::SRC_W-1:0]    src_r;
  logic                         audio_r;

  // Working values
  logic [pse_pkg::STATUS_W-1:0] status_r;
  logic [pse_pkg::MSEL_W-1:0]   msel_r;
  logic [pse_pkg::PSEL_W-1:0]   psel_r;
  logic                         even_r;
  logic [pse_pkg::CCO_W-1:0]    cco_r;
  logic [pse_pkg::FREQ_W-1:0]   expect_r;
  logic [pse_pkg::SELI_W-1:0]   seli_r;
  logic [pse_pkg::MDEC_W-1:0]   mdec_r;
  logic [pse_pkg::PDEC_W-1:0]   pdec_r;

  // Result register
  logic                         out_valid_r;
  logic [pse_pkg::STATUS_W-1:0] o_status_r;
  logic [pse_pkg::MDEC_W-1:0]   o_mdec_r;
  logic [pse_pkg::NDEC_W-1:0]   o_ndec_r;
  logic [pse_pkg::PDEC_W-1:0]   o_pdec_r;
  logic [pse_pkg::SELI_W-1:0]   o_seli_r;
  logic [pse_pkg::SELP_W-1:0]   o_selp_r;
  logic                         o_dir_in_r;
  logic                         o_dir_out_r;
  logic                         o_audio_r;
  logic [pse_pkg::SRC_W-1:0]    o_src_r;
  logic [pse_pkg::FREQ_W-1:0]   o_freq_r;

  // Per-channel record of the last accepted expected frequency
  logic [pse_pkg::FREQ_W-1:0]   audio_freq_r;
  logic [pse_pkg::FREQ_W-1:0]   usb_freq_r;

  pse_pkg::div_req_t  div_req;
  pse_pkg::div_rsp_t  div_rsp;
  pse_pkg::lfsr_req_t lfsr_req;
  pse_pkg::lfsr_rsp_t lfsr_rsp;

  logic                         in_xfer;
  logic                         div_bad;
  logic                         mult_bad;
  logic [pse_pkg::STATUS_W-1:0] check_status;
  logic [pse_pkg::FREQ_W-1:0]   fin_half;
  logic                         cco_ok;
  logic                         band_div;
  logic [pse_pkg::SELI_W-1:0]   seli_direct;
  logic                         msel_lfsr;
  logic                         psel_lfsr;
  logic                         load_out;
  logic                         ok;
  logic [pse_pkg::MULT_W-1:0]   m_steps;
  logic [pse_pkg::PSEL_W-1:0]   p_steps;
  logic [pse_pkg::SELP_W-1:0]   selp_val;

  pse_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pse_lfsr_unit u_lfsr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lfsr_req),
    .rsp   (lfsr_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Checks in order: divisor, multiplier, idle source
  assign div_bad  = (div_r == '0) || (div_r > pse_pkg::DIV_MAX) ||
                    ((div_r > pse_pkg::DIV_W'(1)) && div_r[0]);
  assign mult_bad = (mult_r == '0) || (mult_r > pse_pkg::MULT_MAX);

  always_comb begin
    priority if (div_bad || mult_bad) begin
      check_status = pse_pkg::ST_INVALID;
    end else if (fin_r == '0) begin
      check_status = pse_pkg::ST_IDLE;
    end else begin
      check_status = pse_pkg::ST_OK;
    end
  end

  // Odd M divides the reference by two first
  assign fin_half = even_r ? fin_r : {1'b0, fin_r[pse_pkg::FREQ_W-1:1]};
  assign cco_ok   = (cco_r >= pse_pkg::CCO_MIN) && (cco_r <= pse_pkg::CCO_MAX);

  // Bandwidth current select; the 60..500 band needs a division
  assign band_div = (msel_r >= pse_pkg::BW_T5) && (msel_r < pse_pkg::BW_T4);

  always_comb begin
    priority if (msel_r > pse_pkg::BW_T1) begin
      seli_direct = pse_pkg::SELI_W'(1);
    end else if (msel_r > pse_pkg::BW_T2) begin
      seli_direct = pse_pkg::SELI_W'(2);
    end else if (msel_r > pse_pkg::BW_T3) begin
      seli_direct = pse_pkg::SELI_W'(4);
    end else if (msel_r >= pse_pkg::BW_T4) begin
      seli_direct = pse_pkg::SELI_W'(8);
    end else begin
      seli_direct = pse_pkg::SELI_W'({msel_r[5:2], 2'b00}) + pse_pkg::SELI_W'(4);
    end
  end

  assign selp_val = (msel_r < pse_pkg::BW_T5) ?
                    (pse_pkg::SELP_W'(msel_r[5:1]) + pse_pkg::SELP_W'(1)) :
                    pse_pkg::SELP_W'(31);

  assign msel_lfsr = msel_r >= pse_pkg::MSEL_W'(3);
  assign psel_lfsr = psel_r >= pse_pkg::PSEL_W'(3);
  assign m_steps   = pse_pkg::M_STEPS_BASE - {1'b0, msel_r};
  assign p_steps   = pse_pkg::P_STEPS_BASE - psel_r;

  assign ok       = (status_r == pse_pkg::ST_OK);
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // Sequencer and unit requests
  always_comb begin
    state_nxt         = state_r;
    div_req.start     = 1'b0;
    div_req.dividend  = cco_r[pse_pkg::FREQ_W:1];
    div_req.divisor   = pse_pkg::DVS_W'(psel_r);
    lfsr_req.start    = 1'b0;
    lfsr_req.mode_p   = 1'b0;
    lfsr_req.steps    = m_steps[pse_pkg::LFSR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = (check_status == pse_pkg::ST_OK) ? S_MUL : S_FIN;
      end
      S_MUL: begin
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (!cco_ok) begin
          state_nxt = S_FIN;
        end else if (psel_r != '0) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIVF;
        end else begin
          state_nxt = S_BAND;
        end
      end
      S_DIVF: begin
        if (div_rsp.done) state_nxt = S_BAND;
      end
      S_BAND: begin
        if (band_div) begin
          div_req.start    = 1'b1;
          div_req.dividend = pse_pkg::BW_NUM;
          div_req.divisor  = msel_r[pse_pkg::DVS_W-1:0] + pse_pkg::BW_OFS;
          state_nxt        = S_DIVB;
        end else begin
          state_nxt = S_LFM_GO;
        end
      end
      S_DIVB: begin
        if (div_rsp.done) state_nxt = S_LFM_GO;
      end
      S_LFM_GO: begin
        if (msel_lfsr) begin
          lfsr_req.start = 1'b1;
          state_nxt      = S_LFM_WT;
        end else begin
          state_nxt = S_LFP_GO;
        end
      end
      S_LFM_WT: begin
        if (lfsr_rsp.done) state_nxt = S_LFP_GO;
      end
      S_LFP_GO: begin
        lfsr_req.mode_p = 1'b1;
        lfsr_req.steps  = pse_pkg::LFSR_W'(p_steps);
        if (psel_lfsr) begin
          lfsr_req.start = 1'b1;
          state_nxt      = S_LFP_WT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LFP_WT: begin
        if (lfsr_rsp.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      audio_freq_r <= '0;
      usb_freq_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Record the channel frequency only for an accepted request
      if (load_out && ok) begin
        if (audio_r) begin
          audio_freq_r <= expect_r;
        end else begin
          usb_freq_r <= expect_r;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mult_r <= in_ch.multiplier;
      div_r  <= in_ch.divisor;
      fin_r  <= in_ch.source_frequency;
      src_r  <= in_ch.source_select;
      audio_r <= in_ch.is_audio;
    end
    unique case (state_r)
      S_CHECK: begin
        status_r <= check_status;
        even_r   <= ~mult_r[0];
        msel_r   <= mult_r[0] ? mult_r[pse_pkg::MSEL_W-1:0]
                              : mult_r[pse_pkg::MSEL_W:1];
        psel_r   <= (div_r > pse_pkg::DIV_W'(1)) ? div_r[pse_pkg::DIV_W-1:1] : '0;
      end
      S_MUL: begin
        cco_r <= pse_pkg::CCO_W'(fin_half * {msel_r, 1'b0});
      end
      S_RANGE: begin
        if (!cco_ok) status_r <= pse_pkg::ST_INVALID;
        expect_r <= cco_r[pse_pkg::FREQ_W-1:0];
      end
      S_DIVF: begin
        if (div_rsp.done) expect_r <= div_rsp.quotient;
      end
      S_BAND: begin
        seli_r <= seli_direct;
      end
      S_DIVB: begin
        if (div_rsp.done) seli_r <= {div_rsp.quotient[4:0], 2'b00};
      end
      S_LFM_GO: begin
        if (msel_r == pse_pkg::MSEL_W'(1)) begin
          mdec_r <= pse_pkg::MDEC_ONE;
        end else if (msel_r == pse_pkg::MSEL_W'(2)) begin
          mdec_r <= pse_pkg::MDEC_TWO;
        end
      end
      S_LFM_WT: begin
        if (lfsr_rsp.done) mdec_r <= pse_pkg::MDEC_W'(lfsr_rsp.value);
      end
      S_LFP_GO: begin
        if (psel_r == '0) begin
          pdec_r <= pse_pkg::PDEC_DIRECT;
        end else if (psel_r == pse_pkg::PSEL_W'(1)) begin
          pdec_r <= pse_pkg::PDEC_ONE;
        end else if (psel_r == pse_pkg::PSEL_W'(2)) begin
          pdec_r <= pse_pkg::PDEC_TWO;
        end
      end
      S_LFP_WT: begin
        if (lfsr_rsp.done) pdec_r <= {2'b00, lfsr_rsp.value[4:0]};
      end
      default: begin
      end
    endcase
  end

  // Result register; a rejected request drops every field but status to zero
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_status_r  <= status_r;
      o_mdec_r    <= ok ? mdec_r : '0;
      o_ndec_r    <= ok ? (even_r ? pse_pkg::NDEC_ONE : pse_pkg::NDEC_TWO) : '0;
      o_pdec_r    <= ok ? pdec_r : '0;
      o_seli_r    <= ok ? seli_r : '0;
      o_selp_r    <= ok ? selp_val : '0;
      o_dir_in_r  <= ok && even_r;
      o_dir_out_r <= ok && (psel_r == '0);
      o_audio_r   <= ok && audio_r;
      o_src_r     <= ok ? src_r : '0;
      o_freq_r    <= ok ? expect_r : '0;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = o_status_r;
  assign out_ch.mdec               = o_mdec_r;
  assign out_ch.ndec               = o_ndec_r;
  assign out_ch.pdec               = o_pdec_r;
  assign out_ch.seli               = o_seli_r;
  assign out_ch.selp               = o_selp_r;
  assign out_ch.direct_input       = o_dir_in_r;
  assign out_ch.direct_output      = o_dir_out_r;
  assign out_ch.audio_extras       = o_audio_r;
  assign out_ch.clock_source       = o_src_r;
  assign out_ch.expected_frequency = o_freq_r;

endmodule

`default_nettype wire
